>>> sv/pcss_pkg.sv
`timescale 1ns / 1ps
package pcss_pkg;

  localparam int CAT_W      = 4;
  localparam int LABEL_W    = 8;
  localparam int SCORE_W    = 32;
  localparam int SUM_W      = 56;
  localparam int SQ_W       = 64;
  localparam int CNT_W      = 32;
  localparam int USE_W      = 5;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 168;
  localparam int ADDR_W     = 4;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] REG_IGNORE_ENABLE = 2'd0;
  localparam logic [1:0] REG_IGNORE_VALUE  = 2'd1;
  localparam logic [1:0] REG_EPOCH_ITERS   = 2'd2;
  localparam logic [1:0] REG_CATS_IN_USE   = 2'd3;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_END    = 1'b1
  } req_kind_t;

  typedef struct packed {
    req_kind_t                  kind;
    logic [CAT_W-1:0]           cat;
    logic                       is_pos;
    logic signed [SCORE_W-1:0]  score;
  } q_entry_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
    logic [31:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] radicand;
  } root_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } root_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQR,
    ST_ACC,
    ST_PUB,
    ST_DIV1,
    ST_MUL,
    ST_DIV2,
    ST_ROOT_GO,
    ST_ROOT,
    ST_NEXT,
    ST_EMIT,
    ST_FIN,
    ST_DIV3
  } back_state_t;

endpackage

>>> sv/per_class_score_statistics.sv
`timescale 1ns / 1ps
// Per-category running score statistics. Sample requests enter on the s_ channel
// (s_tuser low) and are classified as positive or negative for their category;
// an end-of-iteration request (s_tuser high) publishes mean and standard deviation
// for each category in use and sends one result per category on the m_ channel,
// with m_tlast on the final category.
// A request waits in a four-entry queue between the classifying front and the
// arithmetic back, so the input keeps flowing while the back is busy.
// A sample request passes through the back in order: fetch, square, update.
// Each published category is worked out per class: a class with samples runs two
// divisions on one shared serial divider and a square root on a serial root unit,
// and a class with no samples skips from PUB to NEXT. The result then waits
// in the output register until taken. After the last result, a 64-step division
// tests for the end of an epoch when the epoch length is not zero.
// While m_tready is low the result is held and the back stops; requests then
// pile up in the queue until s_tready falls.
// Reset is synchronous: all sums, published values and the iteration count clear
// and registers reset. The user configures through the APB port (byte addresses
// 0, 4, 8 and 12) only while the block is idle; the block does not enforce this.
module per_class_score_statistics #(
  parameter int MAX_CATEGORIES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // label[7:0], category[11:8], score[43:12]
  input  logic [pcss_pkg::IN_DATA_W-1:0]  s_tdata,
  // req_type[0]
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // out_category[3:0], positive_mean[35:4], positive_spread[67:36],
  // negative_mean[99:68], negative_spread[131:100], positive_total[163:132]
  output logic [pcss_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tlast,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pcss_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import pcss_pkg::*;

  localparam int NCAT = (MAX_CATEGORIES < 16) ? MAX_CATEGORIES : 16;

  logic             ignore_enable;
  logic [7:0]       ignore_value;
  logic [31:0]      epoch_iterations;
  logic [USE_W-1:0] categories_in_use;
  logic [USE_W-1:0] n_use;
  logic             wr_en;

  q_entry_t  wdata;
  q_entry_t  head;
  logic      push;
  logic      pop;
  logic      full;
  logic      empty;
  div_req_t  dreq;
  div_rsp_t  drsp;
  root_req_t rreq;
  root_rsp_t rrsp;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ignore_enable     <= 1'b0;
      ignore_value      <= '0;
      epoch_iterations  <= '0;
      categories_in_use <= USE_W'(16);
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_IGNORE_ENABLE: ignore_enable     <= pwdata[0];
        REG_IGNORE_VALUE:  ignore_value      <= pwdata[7:0];
        REG_EPOCH_ITERS:   epoch_iterations  <= pwdata;
        REG_CATS_IN_USE:   categories_in_use <= pwdata[USE_W-1:0];
        default:           ignore_enable     <= ignore_enable;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_IGNORE_ENABLE: prdata = {31'b0, ignore_enable};
      REG_IGNORE_VALUE:  prdata = {24'b0, ignore_value};
      REG_EPOCH_ITERS:   prdata = epoch_iterations;
      REG_CATS_IN_USE:   prdata = {27'b0, categories_in_use};
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    if (categories_in_use == '0) begin
      n_use = USE_W'(1);
    end else if (categories_in_use > USE_W'(NCAT)) begin
      n_use = USE_W'(NCAT);
    end else begin
      n_use = categories_in_use;
    end
  end

  pcss_front u_front (
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .ignore_enable (ignore_enable),
    .ignore_value  (ignore_value),
    .n_use         (n_use),
    .full          (full),
    .push          (push),
    .wdata         (wdata)
  );

  pcss_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wdata),
    .pop   (pop),
    .head  (head),
    .full  (full),
    .empty (empty)
  );

  pcss_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  pcss_root u_root (
    .clk (clk),
    .rst (rst),
    .req (rreq),
    .rsp (rrsp)
  );

  pcss_back #(
    .NCAT (NCAT)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .n_use            (n_use),
    .epoch_iterations (epoch_iterations),
    .head             (head),
    .empty            (empty),
    .pop              (pop),
    .dreq             (dreq),
    .drsp             (drsp),
    .rreq             (rreq),
    .rrsp             (rrsp),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tlast          (m_tlast)
  );

endmodule

>>> sv/pcss_front.sv
`timescale 1ns / 1ps
module pcss_front (
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [pcss_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic                           s_tuser,
  input  logic                           ignore_enable,
  input  logic [7:0]                     ignore_value,
  input  logic [pcss_pkg::USE_W-1:0]     n_use,
  input  logic                           full,
  output logic                           push,
  output pcss_pkg::q_entry_t             wdata
);
  import pcss_pkg::*;

  logic [LABEL_W-1:0] label;
  logic [CAT_W-1:0]   cat;
  logic               drop;
  logic               accept;

  assign label    = s_tdata[7:0];
  assign cat      = s_tdata[11:8];
  assign s_tready = !full && !rst;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    drop = 1'b0;
    if (req_kind_t'(s_tuser) == REQ_SAMPLE) begin
      if (ignore_enable && (label == ignore_value)) begin
        drop = 1'b1;
      end
      if ({1'b0, cat} >= n_use) begin
        drop = 1'b1;
      end
    end
  end

  assign push         = accept && !drop;
  assign wdata.kind   = req_kind_t'(s_tuser);
  assign wdata.cat    = cat;
  assign wdata.is_pos = ({4'b0, cat} == label);
  assign wdata.score  = s_tdata[43:12];

endmodule

>>> sv/pcss_queue.sv
`timescale 1ns / 1ps
module pcss_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  pcss_pkg::q_entry_t wdata,
  input  logic               pop,
  output pcss_pkg::q_entry_t head,
  output logic               full,
  output logic               empty
);
  import pcss_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  q_entry_t        slots [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     fill;

  assign full  = (fill == (PW+1)'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

>>> sv/pcss_div.sv
`timescale 1ns / 1ps
module pcss_div (
  input  logic               clk,
  input  logic               rst,
  input  pcss_pkg::div_req_t req,
  output pcss_pkg::div_rsp_t rsp
);
  import pcss_pkg::*;

  logic [63:0] dvd;
  logic [31:0] dvs;
  logic [31:0] rem;
  logic [6:0]  steps;
  logic        busy;
  logic        done;
  logic [32:0] shifted;
  logic        ge;

  assign shifted = {rem, dvd[63]};
  assign ge      = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= 7'd64;
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? 32'(shifted - {1'b0, dvs}) : shifted[31:0];
      dvd <= {dvd[62:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = dvd;
  assign rsp.rem  = rem;

endmodule

>>> sv/pcss_root.sv
`timescale 1ns / 1ps
module pcss_root (
  input  logic                clk,
  input  logic                rst,
  input  pcss_pkg::root_req_t req,
  output pcss_pkg::root_rsp_t rsp
);
  import pcss_pkg::*;

  logic [63:0] rad;
  logic [33:0] rem;
  logic [31:0] root;
  logic [5:0]  steps;
  logic        busy;
  logic        done;
  logic [35:0] shifted;
  logic [35:0] trial;
  logic        ge;

  assign shifted = {rem, rad[63:62]};
  assign trial   = {2'b0, root, 2'b01};
  assign ge      = (shifted >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= 6'd32;
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rad  <= req.radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rem  <= ge ? 34'(shifted - trial) : shifted[33:0];
      root <= {root[30:0], ge};
      rad  <= {rad[61:0], 2'b00};
    end
  end

  assign rsp.done = done;
  assign rsp.root = root;

endmodule

>>> sv/pcss_back.sv
`timescale 1ns / 1ps
module pcss_back #(
  parameter int NCAT = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [pcss_pkg::USE_W-1:0]      n_use,
  input  logic [31:0]                     epoch_iterations,
  input  pcss_pkg::q_entry_t              head,
  input  logic                            empty,
  output logic                            pop,
  output pcss_pkg::div_req_t              dreq,
  input  pcss_pkg::div_rsp_t              drsp,
  output pcss_pkg::root_req_t             rreq,
  input  pcss_pkg::root_rsp_t             rrsp,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [pcss_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tlast
);
  import pcss_pkg::*;

  localparam int IW = $clog2(NCAT);
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  back_state_t state;
  back_state_t state_next;

  logic [CNT_W-1:0]        cnt_a  [2][NCAT];
  logic signed [SUM_W-1:0] sum_a  [2][NCAT];
  logic [SQ_W-1:0]         sq_a   [2][NCAT];
  logic signed [31:0]      mean_a [2][NCAT];
  logic [31:0]             std_a  [2][NCAT];
  logic [31:0]             pcnt_a [NCAT];

  q_entry_t           ent;
  logic [CAT_W-1:0]   c;
  logic               cls;
  logic [63:0]        sq_r;
  logic signed [31:0] mean_r;
  logic [31:0]        am_r;
  logic [63:0]        m2_r;
  logic [63:0]        var_r;
  logic [31:0]        it_cnt;

  logic [CAT_W-1:0]   o_cat;
  logic [31:0]        o_pmean;
  logic [31:0]        o_pstd;
  logic [31:0]        o_nmean;
  logic [31:0]        o_nstd;
  logic [31:0]        o_pcnt;
  logic               o_last;

  logic [IW-1:0]           ai;
  logic                    acl;
  logic [IW-1:0]           pi;
  logic [CNT_W-1:0]        cur_cnt;
  logic signed [SUM_W-1:0] cur_sum;
  logic [SQ_W-1:0]         cur_sq;
  logic [SUM_W-1:0]        sum_mag;
  logic signed [SUM_W:0]   acc_sum;
  logic [SQ_W:0]           acc_sq;
  logic [31:0]             score_mag;
  logic [63:0]             q1;
  logic [31:0]             am_next;
  logic                    last_cat;

  assign ai       = ent.cat[IW-1:0];
  assign acl      = !ent.is_pos;
  assign pi       = c[IW-1:0];
  assign cur_cnt  = cnt_a[cls][pi];
  assign cur_sum  = sum_a[cls][pi];
  assign cur_sq   = sq_a[cls][pi];
  assign sum_mag  = cur_sum[SUM_W-1] ? SUM_W'(-cur_sum) : SUM_W'(cur_sum);
  assign acc_sum  = {sum_a[acl][ai][SUM_W-1], sum_a[acl][ai]}
                  + (SUM_W+1)'(ent.score);
  assign acc_sq   = {1'b0, sq_a[acl][ai]} + {1'b0, sq_r};
  assign score_mag = ent.score[31] ? 32'(-ent.score) : 32'(ent.score);
  assign q1       = drsp.quot;
  assign last_cat = ({1'b0, c} == USE_W'(n_use - 1'b1));

  always_comb begin
    if (cur_sum[SUM_W-1]) begin
      am_next = (q1 > 64'h8000_0000) ? 32'h8000_0000 : q1[31:0];
    end else begin
      am_next = (q1 > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q1[31:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!empty) begin
          state_next = (head.kind == REQ_SAMPLE) ? ST_SQR : ST_PUB;
        end
      end
      ST_SQR:     state_next = ST_ACC;
      ST_ACC:     state_next = ST_IDLE;
      ST_PUB:     state_next = (cur_cnt != '0) ? ST_DIV1 : ST_NEXT;
      ST_DIV1:    state_next = drsp.done ? ST_MUL : ST_DIV1;
      ST_MUL:     state_next = ST_DIV2;
      ST_DIV2:    state_next = drsp.done ? ST_ROOT_GO : ST_DIV2;
      ST_ROOT_GO: state_next = ST_ROOT;
      ST_ROOT:    state_next = rrsp.done ? ST_NEXT : ST_ROOT;
      ST_NEXT:    state_next = cls ? ST_EMIT : ST_PUB;
      ST_EMIT: begin
        if (m_tready) begin
          state_next = last_cat ? ST_FIN : ST_PUB;
        end
      end
      ST_FIN:     state_next = (epoch_iterations != '0) ? ST_DIV3 : ST_IDLE;
      ST_DIV3:    state_next = drsp.done ? ST_IDLE : ST_DIV3;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop           = 1'b0;
    dreq.start    = 1'b0;
    dreq.dividend = {8'b0, sum_mag};
    dreq.divisor  = cur_cnt;
    rreq.start    = 1'b0;
    rreq.radicand = var_r;
    m_tvalid      = 1'b0;
    case (state)
      ST_IDLE: pop = !empty;
      ST_PUB:  dreq.start = (cur_cnt != '0);
      ST_MUL: begin
        dreq.start    = 1'b1;
        dreq.dividend = cur_sq;
      end
      ST_ROOT_GO: rreq.start = 1'b1;
      ST_EMIT:    m_tvalid = 1'b1;
      ST_FIN: begin
        dreq.start    = (epoch_iterations != '0);
        dreq.dividend = {32'b0, it_cnt + 32'd1};
        dreq.divisor  = epoch_iterations;
      end
      default: pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      c      <= '0;
      cls    <= 1'b0;
      it_cnt <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          c   <= '0;
          cls <= 1'b0;
        end
        ST_NEXT: cls <= 1'b1;
        ST_EMIT: begin
          if (m_tready) begin
            c   <= c + 1'b1;
            cls <= 1'b0;
          end
        end
        ST_FIN:  it_cnt <= it_cnt + 32'd1;
        default: cls <= cls;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      ent <= head;
    end
    if (state == ST_SQR) begin
      sq_r <= score_mag * score_mag;
    end
    if (state == ST_DIV1 && drsp.done) begin
      am_r   <= am_next;
      mean_r <= cur_sum[SUM_W-1] ? 32'(-am_next) : 32'(am_next);
    end
    if (state == ST_MUL) begin
      m2_r <= am_r * am_r;
    end
    if (state == ST_DIV2 && drsp.done) begin
      var_r <= (q1 > m2_r) ? (q1 - m2_r) : '0;
    end
    if (state == ST_NEXT && cls) begin
      o_cat   <= c;
      o_pmean <= mean_a[0][pi];
      o_pstd  <= std_a[0][pi];
      o_nmean <= mean_a[1][pi];
      o_nstd  <= std_a[1][pi];
      o_pcnt  <= pcnt_a[pi];
      o_last  <= last_cat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NCAT; k++) begin
        for (int j = 0; j < 2; j++) begin
          cnt_a[j][k]  <= '0;
          sum_a[j][k]  <= '0;
          sq_a[j][k]   <= '0;
          mean_a[j][k] <= '0;
          std_a[j][k]  <= '0;
        end
        pcnt_a[k] <= '0;
      end
    end else begin
      if (state == ST_ACC && cnt_a[acl][ai] != '1) begin
        cnt_a[acl][ai] <= cnt_a[acl][ai] + 1'b1;
        if (acc_sum[SUM_W] != acc_sum[SUM_W-1]) begin
          sum_a[acl][ai] <= acc_sum[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
          sum_a[acl][ai] <= acc_sum[SUM_W-1:0];
        end
        sq_a[acl][ai] <= acc_sq[SQ_W] ? '1 : acc_sq[SQ_W-1:0];
      end
      if (state == ST_ROOT && rrsp.done) begin
        mean_a[cls][pi] <= mean_r;
        std_a[cls][pi]  <= rrsp.root;
        if (!cls) begin
          pcnt_a[pi] <= cur_cnt;
        end
      end
      if (state == ST_DIV3 && drsp.done && drsp.rem == '0) begin
        for (int k = 0; k < NCAT; k++) begin
          for (int j = 0; j < 2; j++) begin
            cnt_a[j][k] <= '0;
            sum_a[j][k] <= '0;
            sq_a[j][k]  <= '0;
          end
        end
      end
    end
  end

  assign m_tdata = {4'b0, o_pcnt, o_nstd, o_nmean, o_pstd, o_pmean, o_cat};
  assign m_tlast = o_last;

endmodule

>>> sv/pcss_checker.sv
`timescale 1ns / 1ps
module pcss_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [pcss_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tlast
);
  import pcss_pkg::*;

  a_hold_valid : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result withdrawn while stalled");

  a_hold_data : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  a_reset_quiet : assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result shown straight after reset");

  a_gap_between : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> !m_tvalid)
    else $error("next category published without computing it");

endmodule

bind per_class_score_statistics pcss_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

>>> test/tb.sv
`timescale 1ns / 1ps
module tb;
  import pcss_pkg::*;

  typedef struct {
    req_kind_t          kind;
    logic [7:0]         label;
    logic [3:0]         cat;
    logic signed [31:0] score;
  } request_t;

  typedef struct {
    logic [3:0]  cat;
    logic [31:0] pos_mean;
    logic [31:0] pos_spread;
    logic [31:0] neg_mean;
    logic [31:0] neg_spread;
    logic [31:0] pos_total;
    logic        last;
  } stats_t;

  localparam longint SUM_HI = 64'sh007F_FFFF_FFFF_FFFF;
  localparam longint SUM_LO = -SUM_HI - 1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  per_class_score_statistics dut (.*);

  always #5 clk = ~clk;

  // Predictor state.
  logic [31:0]  cfg_ignore_en, cfg_ignore_val, cfg_epoch, cfg_cats;
  logic [31:0]  pos_cnt [16], neg_cnt [16];
  longint       pos_sum [16], neg_sum [16];
  logic [63:0]  pos_sq [16], neg_sq [16];
  logic [31:0]  pub_pm [16], pub_ps [16], pub_nm [16], pub_ns [16], pub_pt [16];
  logic [31:0]  iterations;

  request_t pending_requests [$];
  stats_t   expected_stats [$];
  int errors = 0, samples_sent = 0, ends_sent = 0, results_checked = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    if (errors <= 30)
      $display("Mismatch in %s at %0t: got %h, expected %h", what, $time, got, want);
  endtask

  function automatic logic [31:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[31:0];
  endfunction

  task automatic accumulate(inout logic [31:0] cnt, inout longint sum, inout logic [63:0] sq,
                            input longint s);
    logic [63:0] mag, p;
    longint t;
    mag = (s < 0) ? -s : s;
    p = mag * mag;
    if (cnt == 32'hFFFF_FFFF) return;
    cnt++;
    t = sum + s;
    if (t > SUM_HI) t = SUM_HI;
    if (t < SUM_LO) t = SUM_LO;
    sum = t;
    sq = (sq > 64'hFFFF_FFFF_FFFF_FFFF - p) ? 64'hFFFF_FFFF_FFFF_FFFF : sq + p;
  endtask

  task automatic class_stats(input logic [31:0] cnt, input longint sum, input logic [63:0] sq,
                             output logic [31:0] mean, output logic [31:0] spread);
    logic [63:0] mag, q, am, msq, m2;
    longint m;
    mag = (sum < 0) ? -sum : sum;
    q = mag / {32'd0, cnt};
    if (sum < 0) m = (q > 64'h8000_0000) ? -64'sh8000_0000 : -longint'(q);
    else m = (q > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(q);
    am = (m < 0) ? -m : m;
    m2 = am * am;
    msq = sq / {32'd0, cnt};
    mean = m[31:0];
    spread = int_sqrt((msq > m2) ? msq - m2 : 64'd0);
  endtask

  task automatic apply_request(input request_t r);
    int n;
    stats_t st;
    n = (cfg_cats == 0) ? 1 : (cfg_cats > 16 ? 16 : cfg_cats);
    if (r.kind == REQ_SAMPLE) begin
      if (cfg_ignore_en[0] && r.label == cfg_ignore_val[7:0]) return;
      if (r.cat >= n) return;
      if ({4'd0, r.cat} == r.label)
        accumulate(pos_cnt[r.cat], pos_sum[r.cat], pos_sq[r.cat], longint'(r.score));
      else
        accumulate(neg_cnt[r.cat], neg_sum[r.cat], neg_sq[r.cat], longint'(r.score));
      return;
    end
    for (int c = 0; c < n; c++) begin
      if (pos_cnt[c] > 0) begin
        class_stats(pos_cnt[c], pos_sum[c], pos_sq[c], pub_pm[c], pub_ps[c]);
        pub_pt[c] = pos_cnt[c];
      end
      if (neg_cnt[c] > 0) class_stats(neg_cnt[c], neg_sum[c], neg_sq[c], pub_nm[c], pub_ns[c]);
    end
    for (int c = 0; c < n; c++) begin
      st.cat = c[3:0];
      st.pos_mean = pub_pm[c];
      st.pos_spread = pub_ps[c];
      st.neg_mean = pub_nm[c];
      st.neg_spread = pub_ns[c];
      st.pos_total = pub_pt[c];
      st.last = (c == n - 1);
      expected_stats.push_back(st);
    end
    iterations++;
    if (cfg_epoch != 0 && iterations % cfg_epoch == 0) begin
      for (int c = 0; c < 16; c++) begin
        pos_cnt[c] = 0; neg_cnt[c] = 0; pos_sum[c] = 0; neg_sum[c] = 0;
        pos_sq[c] = 0; neg_sq[c] = 0;
      end
    end
  endtask

  // Driver: bursts of requests separated by random gaps.
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    logic valid_next;
    valid_next = 1'b0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        apply_request(pending_requests.pop_front());
        if (burst_left > 0) burst_left--;
      end
      if (gap_left > 0) begin
        gap_left--;
      end else if (burst_left == 0 && $urandom_range(0, 2) != 0) begin
        gap_left = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 14);
      end else begin
        if (burst_left == 0) burst_left = $urandom_range(1, 14);
        if (pending_requests.size() > 0) begin
          valid_next = 1'b1;
          s_tdata <= {4'd0, pending_requests[0].score, pending_requests[0].cat,
                      pending_requests[0].label};
          s_tuser <= pending_requests[0].kind;
        end
      end
    end
    s_tvalid <= valid_next;
  end

  // Monitor with its own stall pattern.
  int stall_phase = 0;
  always @(posedge clk) begin
    stats_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_checked++;
      if (expected_stats.size() == 0) begin
        report("unexpected result", m_tdata[31:0], 32'd0);
      end else begin
        want = expected_stats.pop_front();
        if (m_tdata[3:0] != want.cat) report("category", m_tdata[3:0], want.cat);
        if (m_tdata[35:4] != want.pos_mean) report("positive mean", m_tdata[35:4], want.pos_mean);
        if (m_tdata[67:36] != want.pos_spread)
          report("positive spread", m_tdata[67:36], want.pos_spread);
        if (m_tdata[99:68] != want.neg_mean) report("negative mean", m_tdata[99:68], want.neg_mean);
        if (m_tdata[131:100] != want.neg_spread)
          report("negative spread", m_tdata[131:100], want.neg_spread);
        if (m_tdata[163:132] != want.pos_total)
          report("positive total", m_tdata[163:132], want.pos_total);
        if (m_tlast != want.last) report("last flag", m_tlast, want.last);
      end
    end
    stall_phase = (stall_phase + 1) % 40;
    m_tready <= (stall_phase < 15) ? 1'b1 : ($urandom_range(0, 3) != 0);
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_IGNORE_ENABLE: cfg_ignore_en = value & 32'h1;
      REG_IGNORE_VALUE:  cfg_ignore_val = value & 32'hFF;
      REG_EPOCH_ITERS:   cfg_epoch = value;
      REG_CATS_IN_USE:   cfg_cats = value & 32'h1F;
      default:           cfg_epoch = cfg_epoch;
    endcase
  endtask

  task automatic push_item(input req_kind_t k, input logic [7:0] lab, input logic [3:0] c,
                           input logic [31:0] s);
    request_t r;
    r.kind = k; r.label = lab; r.cat = c; r.score = s;
    pending_requests.push_back(r);
    if (k == REQ_SAMPLE) samples_sent++; else ends_sent++;
  endtask

  task automatic drain;
    while (pending_requests.size() > 0 || expected_stats.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic random_phase(input int count, input int n);
    logic [31:0] s;
    logic [3:0] c;
    logic [7:0] lab;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        push_item(REQ_END, 8'($urandom), 4'($urandom), $urandom);
      end else begin
        c = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, n - 1));
        case ($urandom_range(0, 3))
          0: lab = {4'd0, c};
          1: lab = 8'($urandom);
          default: lab = 8'($urandom_range(0, 15));
        endcase
        case ($urandom_range(0, 3))
          0: s = $urandom;
          1: s = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
          2: s = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 255)
                                      : 32'h8000_0000 + $urandom_range(0, 255);
          default: s = $urandom_range(0, 32'h00FF_FFFF) << $urandom_range(0, 8);
        endcase
        push_item(REQ_SAMPLE, lab, c, s);
      end
    end
    push_item(REQ_END, 8'd0, 4'd0, 32'd0);
    drain();
  endtask

  initial begin
    int n;
    cfg_ignore_en = 0; cfg_ignore_val = 0; cfg_epoch = 0; cfg_cats = 16; iterations = 0;
    for (int c = 0; c < 16; c++) begin
      pos_cnt[c] = 0; neg_cnt[c] = 0; pos_sum[c] = 0; neg_sum[c] = 0; pos_sq[c] = 0;
      neg_sq[c] = 0; pub_pm[c] = 0; pub_ps[c] = 0; pub_nm[c] = 0; pub_ns[c] = 0; pub_pt[c] = 0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    push_item(REQ_END, 8'd0, 4'd0, 32'd0);
    push_item(REQ_SAMPLE, 8'd0, 4'd0, 32'h7FFF_FFFF);
    push_item(REQ_SAMPLE, 8'd0, 4'd0, 32'h8000_0000);
    push_item(REQ_SAMPLE, 8'd1, 4'd0, 32'h0000_0000);
    push_item(REQ_SAMPLE, 8'd15, 4'd15, 32'hFFFF_FFFF);
    push_item(REQ_SAMPLE, 8'd255, 4'd3, 32'h0001_8000);
    for (int i = 0; i < 5; i++) push_item(REQ_SAMPLE, 8'd9, 4'd2, 32'h8000_0000);
    push_item(REQ_SAMPLE, 8'd2, 4'd2, 32'h0000_0001);
    push_item(REQ_END, 8'd0, 4'd0, 32'd0);
    drain();

    reg_write(REG_IGNORE_ENABLE, 32'd1);
    reg_write(REG_IGNORE_VALUE, 32'd7);
    reg_write(REG_EPOCH_ITERS, 32'd1);
    reg_write(REG_CATS_IN_USE, 32'd3);
    push_item(REQ_SAMPLE, 8'd7, 4'd1, 32'h0005_0000);
    push_item(REQ_SAMPLE, 8'd5, 4'd5, 32'h0005_0000);
    push_item(REQ_SAMPLE, 8'd1, 4'd1, 32'h0003_0000);
    push_item(REQ_END, 8'd0, 4'd0, 32'd0);
    push_item(REQ_END, 8'd0, 4'd0, 32'd0);
    drain();
    reg_write(REG_CATS_IN_USE, 32'd0);
    push_item(REQ_SAMPLE, 8'd0, 4'd0, 32'h0002_0000);
    push_item(REQ_END, 8'd0, 4'd0, 32'd0);
    drain();
    reg_write(REG_CATS_IN_USE, 32'd31);
    reg_write(REG_IGNORE_VALUE, 32'd255);
    push_item(REQ_SAMPLE, 8'd255, 4'd0, 32'h0002_0000);
    push_item(REQ_END, 8'd0, 4'd0, 32'd0);
    drain();

    for (int p = 0; p < 7; p++) begin
      reg_write(REG_IGNORE_ENABLE, $urandom_range(0, 1));
      reg_write(REG_IGNORE_VALUE, (p % 2) ? $urandom_range(0, 15) : $urandom);
      case (p % 4)
        0: reg_write(REG_EPOCH_ITERS, 32'd0);
        1: reg_write(REG_EPOCH_ITERS, 32'hFFFF_FFFF);
        default: reg_write(REG_EPOCH_ITERS, $urandom_range(1, 4));
      endcase
      n = (p == 2) ? 16 : (p == 5 ? 1 : $urandom_range(2, 8));
      reg_write(REG_CATS_IN_USE, n);
      random_phase(65, n);
    end

    $display("Sent %0d score samples and %0d end-of-iteration requests;", samples_sent, ends_sent);
    $display("checked %0d statistics results over several register settings.", results_checked);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> files.f
sv/pcss_pkg.sv
sv/pcss_front.sv
sv/pcss_queue.sv
sv/pcss_div.sv
sv/pcss_root.sv
sv/pcss_back.sv
sv/per_class_score_statistics.sv
sv/pcss_checker.sv
test/tb.sv
